// File: rtl/core/binary_field_serializer_macros.svh
// Assertion macros used by the binary field serializer RTL.
// No dependencies; included by modules that carry assertions.
`ifndef BINARY_FIELD_SERIALIZER_MACROS_SVH
`define BINARY_FIELD_SERIALIZER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define BFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/bfs_pkg.sv
// Package for the binary field serializer: command codes, FSM state, control structs.
// No dependencies.
package bfs_pkg;

	localparam logic [2:0] CMD_BE8    = 3'd0;
	localparam logic [2:0] CMD_BE16   = 3'd1;
	localparam logic [2:0] CMD_BE32   = 3'd2;
	localparam logic [2:0] CMD_BE64   = 3'd3;
	localparam logic [2:0] CMD_VARINT = 3'd4;
	localparam logic [2:0] CMD_ZIGZAG = 3'd5;

	localparam int VALUE_W = 64;
	localparam int GROUP_W = 7;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       be_mode;
		logic       ld_be;
		logic       ld_zigzag;
		logic [1:0] ld_be_sel;
	} ctrl_t;

	typedef struct packed {
		logic rest_nz;
	} stat_t;

endpackage

// File: rtl/core/bfs_shift_unit.sv
// Shared shift register of the serializer: loads the value, shifts 8 or 7 bits per byte.
// Depends on bfs_pkg.
module bfs_shift_unit import bfs_pkg::*; (
	input  logic                 clk,
	input  ctrl_t                ctrl,
	input  logic [VALUE_W-1:0]   value,
	output stat_t                stat,
	output logic [7:0]           out_byte
);

	logic [VALUE_W-1:0] sh_q;
	logic [VALUE_W-1:0] ld_val;
	logic [VALUE_W-1:0] zz_val;

	assign zz_val = {value[VALUE_W-2:0], 1'b0} ^ {VALUE_W{value[VALUE_W-1]}};

	always_comb begin
		if (ctrl.ld_be) begin
			case (ctrl.ld_be_sel)
				2'd0:    ld_val = {value[7:0], 56'b0};
				2'd1:    ld_val = {value[15:0], 48'b0};
				2'd2:    ld_val = {value[31:0], 32'b0};
				default: ld_val = value;
			endcase
		end else begin
			ld_val = ctrl.ld_zigzag ? zz_val : value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sh_q <= ld_val;
		end else if (ctrl.step) begin
			sh_q <= ctrl.be_mode ? {sh_q[VALUE_W-9:0], 8'b0}
			                     : {{GROUP_W{1'b0}}, sh_q[VALUE_W-1:GROUP_W]};
		end
	end

	assign stat.rest_nz = |sh_q[VALUE_W-1:GROUP_W];
	assign out_byte = ctrl.be_mode ? sh_q[VALUE_W-1:VALUE_W-8]
	                               : {stat.rest_nz, sh_q[GROUP_W-1:0]};

endmodule

// File: rtl/core/bfs_seq.sv
// Sequencer of the serializer: handshakes, byte counter and per-byte shift control.
// Depends on bfs_pkg and binary_field_serializer_macros.svh.
`include "binary_field_serializer_macros.svh"

module bfs_seq import bfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       last,
	input  stat_t      stat,
	output ctrl_t      ctrl
);

	state_t     state_q, state_d;
	logic       be_q;
	logic [3:0] cnt_q;
	logic       cmd_ok;

	assign cmd_ok = command inside {[CMD_BE8:CMD_ZIGZAG]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			be_q    <= 1'b0;
			cnt_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				be_q  <= command inside {[CMD_BE8:CMD_BE64]};
				cnt_q <= 4'b0001 << command[1:0];
			end else if (ctrl.step) begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = (state_q == ST_IDLE);
		out_valid      = (state_q == ST_EMIT);
		last           = be_q ? (cnt_q == 4'd1) : !stat.rest_nz;
		ctrl.load      = in_valid && in_ready && cmd_ok;
		ctrl.step      = out_valid && out_ready;
		ctrl.be_mode   = be_q;
		ctrl.ld_be     = command inside {[CMD_BE8:CMD_BE64]};
		ctrl.ld_zigzag = (command == CMD_ZIGZAG);
		ctrl.ld_be_sel = command[1:0];
		case (state_q)
			ST_IDLE: begin
				if (ctrl.load) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (ctrl.step && last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`BFS_ASSERT_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`BFS_ASSERT_NEXT(a_load_emits, clk, arst_n, ctrl.load, out_valid)
	`BFS_ASSERT_IMPL(a_be_count, clk, arst_n, out_valid && be_q, cnt_q != 4'd0)
	`BFS_ASSERT_NEXT(a_last_ends, clk, arst_n, ctrl.step && last, in_ready)

endmodule

// File: rtl/core/binary_field_serializer.sv
// Binary field serializer: fixed big-endian, varint and zigzag varint byte streams.
// Latency: first byte is offered the cycle after the input transfer.
// Throughput: one byte per cycle while out_ready is high; an item gives N = 1..10 bytes
// (N = 0 for an unused command), and a new item is taken only after its last byte.
// Reset: arst_n asynchronous, active low; returns the sequencer to idle.
// Depends on bfs_pkg, bfs_seq and bfs_shift_unit.
module binary_field_serializer import bfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         command,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last
);

	ctrl_t ctrl;
	stat_t stat;

	bfs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last      (last),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	bfs_shift_unit u_shift (
		.clk      (clk),
		.ctrl     (ctrl),
		.value    (value),
		.stat     (stat),
		.out_byte (out_byte)
	);

endmodule

// File: tb/tb_binary_field_serializer.sv
// Self-checking testbench for binary_field_serializer: directed and random commands,
// random idling on both handshakes, byte stream checked against an internal encoder.
// Depends on bfs_pkg and the binary_field_serializer RTL.
module tb_binary_field_serializer import bfs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;
	localparam int RANDOM_ITEMS = 256;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 160;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} stream_byte_t;

	class byte_stream_board;
		stream_byte_t pending_bytes[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void push_big_endian(logic [63:0] v, int nbytes);
			stream_byte_t b;
			for (int k = 0; k < nbytes; k++) begin
				b.data = 8'(v >> (8 * (nbytes - 1 - k)));
				b.fin  = (k == nbytes - 1);
				pending_bytes.push_back(b);
			end
		endfunction

		function void push_varint(logic [63:0] v);
			stream_byte_t b;
			logic [63:0] rest;
			rest = v;
			do begin
				b.data = {1'b0, rest[6:0]};
				rest   = rest >> 7;
				b.fin  = (rest == 64'd0);
				if (!b.fin)
					b.data[7] = 1'b1;
				pending_bytes.push_back(b);
			end while (!b.fin);
		endfunction

		function void note_input(logic [2:0] cmd, logic [63:0] v);
			case (cmd)
				CMD_BE8:    push_big_endian(v, 1);
				CMD_BE16:   push_big_endian(v, 2);
				CMD_BE32:   push_big_endian(v, 4);
				CMD_BE64:   push_big_endian(v, 8);
				CMD_VARINT: push_varint(v);
				CMD_ZIGZAG: push_varint((v << 1) ^ {64{v[63]}});
				default: ;
			endcase
		endfunction

		function void check_byte(logic [7:0] data, logic fin);
			stream_byte_t exp_b;
			if (pending_bytes.size() == 0) begin
				$error("unexpected byte: out_byte %h last %b", data, fin);
				errors++;
			end else begin
				exp_b = pending_bytes.pop_front();
				if (data !== exp_b.data) begin
					$error("out_byte expected %h actual %h", exp_b.data, data);
					errors++;
				end
				if (fin !== exp_b.fin) begin
					$error("last expected %b actual %b", exp_b.fin, fin);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  command;
	logic [63:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        last;

	byte_stream_board board;
	bit calm;
	bit held_once;
	int bytes_seen;
	int idle_cycles;

	binary_field_serializer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.last     (last)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_item(logic [2:0] cmd, logic [63:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		board.note_input(cmd, v);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		int w;
		logic [63:0] v;
		w = $urandom_range(0, 64);
		v = {$urandom(), $urandom()};
		if (w < 64) begin
			v &= (64'd1 << w) - 64'd1;
			if ($urandom_range(0, 3) == 0)
				v = ~v;
		end
		return v;
	endfunction

	function automatic logic [2:0] rand_command();
		case ($urandom_range(0, 19))
			0:       return CMD_RSVD6;
			1:       return CMD_RSVD7;
			2, 3:    return CMD_BE8;
			4, 5:    return CMD_BE16;
			6, 7:    return CMD_BE32;
			8, 9:    return CMD_BE64;
			10, 11, 12, 13, 14: return CMD_VARINT;
			default: return CMD_ZIGZAG;
		endcase
	endfunction

	// output side
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = calm ? 0 : $urandom_range(0, 7);
			if (!held_once && bytes_seen >= HOLD_AT) begin
				held_once = 1'b1;
				w = HOLD_CYCLES;
			end
			if (w != 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_byte(out_byte, last);
			bytes_seen++;
		end
	end

	initial begin
		int sent;
		logic [2:0] cmd;
		board       = new();
		calm        = 1'b0;
		held_once   = 1'b0;
		bytes_seen  = 0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = CMD_BE8;
		value       = 64'd0;
		out_ready   = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(CMD_BE8, 64'd0);
		send_item(CMD_BE8, 64'hff);
		send_item(CMD_BE8, 64'hdead_beef_cafe_ba5a);
		send_item(CMD_BE16, 64'h0123_4567_89ab_cdef);
		send_item(CMD_BE32, 64'hffff_ffff_ffff_ffff);
		send_item(CMD_BE64, 64'h0123_4567_89ab_cdef);
		send_item(CMD_BE64, 64'hffff_ffff_ffff_ffff);
		send_item(CMD_VARINT, 64'd0);
		send_item(CMD_VARINT, 64'd1);
		send_item(CMD_VARINT, 64'd127);
		send_item(CMD_VARINT, 64'd128);
		send_item(CMD_VARINT, 64'h8000_0000_0000_0000);
		send_item(CMD_VARINT, 64'hffff_ffff_ffff_ffff);
		send_item(CMD_ZIGZAG, 64'd0);
		send_item(CMD_ZIGZAG, 64'hffff_ffff_ffff_ffff);
		send_item(CMD_ZIGZAG, 64'd1);
		send_item(CMD_ZIGZAG, 64'h8000_0000_0000_0000);
		send_item(CMD_ZIGZAG, 64'h7fff_ffff_ffff_ffff);
		send_item(CMD_ZIGZAG, 64'hffff_ffff_8000_0000);
		send_item(CMD_ZIGZAG, 64'h0000_0000_7fff_ffff);
		send_item(CMD_RSVD6, 64'h5555_aaaa_5555_aaaa);
		send_item(CMD_RSVD7, 64'haaaa_5555_aaaa_5555);
		send_item(CMD_VARINT, 64'h0000_0000_0000_3fff);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= 100 && sent < 150) || (sent >= 230 && sent < 250);
			cmd = rand_command();
			send_item(cmd, rand_value());
			sent++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (board.pending_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending_bytes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: binary_field_serializer.f
+incdir+rtl/core
rtl/core/bfs_pkg.sv
rtl/core/bfs_shift_unit.sv
rtl/core/bfs_seq.sv
rtl/core/binary_field_serializer.sv
tb/tb_binary_field_serializer.sv
